[rtl/core/text_console_writer_defines.svh]
// Assertion helpers shared by the console RTL.
// Each check samples on the rising edge of clk and is off while rst_n is low.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Check a property that holds at every clock edge.
`define TCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a condition in the next cycle follows from a condition now.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  `TCW_ASSERT(label, (ante) |=> (cons), msg)

`endif

[rtl/core/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

  // Field widths of the stream words
  localparam int OPCODE_W     = 2;
  localparam int CHAR_W       = 8;
  localparam int CELL_INDEX_W = 11;
  localparam int CURSOR_W     = 11;
  localparam int VALUE_W      = 16;
  localparam int ATTR_W       = 8;
  localparam int IN_W         = 24;
  localparam int OUT_W        = 32;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } tcw_op_t;

  // What an accepted item needs after its first cycle
  typedef enum logic [1:0] {
    PATH_DONE,
    PATH_SCROLL,
    PATH_CLEAR,
    PATH_READ
  } tcw_path_t;

  // Which sweep over the screen memory runs this cycle
  typedef enum logic [1:0] {
    SWP_NONE,
    SWP_INIT,
    SWP_FILL,
    SWP_COPY
  } tcw_sweep_t;

  typedef struct packed {
    logic       accept;
    tcw_sweep_t sweep;
    logic       idx_zero;
    logic       idx_last_row;
    logic       load_result;
    logic       result_from_ram;
  } tcw_cmd_t;

  typedef struct packed {
    tcw_path_t path;
    logic      copy_end;
    logic      fill_end;
  } tcw_stat_t;

endpackage

`default_nettype wire

[rtl/core/tcw_ram.sv]
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/tcw_ctrl.sv]
`default_nettype none

`include "text_console_writer_defines.svh"

module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  wire logic      out_tready,
  input  wire tcw_stat_t stat,
  output tcw_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_COPY,
    S_FILL,
    S_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt           = state_r;
    cmd.accept          = 1'b0;
    cmd.sweep           = SWP_NONE;
    cmd.idx_zero        = 1'b0;
    cmd.idx_last_row    = 1'b0;
    cmd.load_result     = 1'b0;
    cmd.result_from_ram = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.sweep = SWP_INIT;
        if (stat.fill_end) begin
          cmd.idx_zero = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          unique case (stat.path)
            PATH_DONE:   cmd.load_result = 1'b1;
            PATH_SCROLL: begin
              cmd.idx_zero = 1'b1;
              state_nxt    = S_COPY;
            end
            PATH_CLEAR: begin
              cmd.idx_zero = 1'b1;
              state_nxt    = S_FILL;
            end
            PATH_READ:   state_nxt = S_READ;
            default:     cmd.load_result = 1'b1;
          endcase
        end
      end
      S_COPY: begin
        cmd.sweep = SWP_COPY;
        if (stat.copy_end) begin
          cmd.idx_last_row = 1'b1;
          state_nxt        = S_FILL;
        end
      end
      S_FILL: begin
        cmd.sweep = SWP_FILL;
        if (stat.fill_end) begin
          cmd.load_result = 1'b1;
          cmd.idx_zero    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_READ: begin
        cmd.load_result     = 1'b1;
        cmd.result_from_ram = 1'b1;
        state_nxt           = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TCW_ASSERT(a_load_free, cmd.load_result |-> (!out_valid_r || out_tready), "result overwrites a held word")
  `TCW_ASSERT_NEXT(a_copy_then_fill, state_r == S_COPY, state_r == S_COPY || state_r == S_FILL, "scroll copy left early")
  `TCW_ASSERT_NEXT(a_fill_done, state_r == S_FILL && stat.fill_end, state_r == S_IDLE && out_valid_r, "fill ended without result")
  `TCW_ASSERT_NEXT(a_read_done, state_r == S_READ, state_r == S_IDLE && out_valid_r, "read gave no result")

endmodule

`default_nettype wire

[rtl/core/tcw_dp.sv]
`default_nettype none

module tcw_dp
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tcw_cmd_t          cmd,
  output tcw_stat_t              stat,
  input  wire logic [IN_W-1:0]   in_tdata,
  input  wire logic              cfg_valid,
  input  wire logic [ATTR_W-1:0] cfg_data,
  output logic      [OUT_W-1:0]  out_tdata
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int OUT_PAD    = OUT_W - CURSOR_W - VALUE_W - 1;

  tcw_op_t                 op;
  logic [CHAR_W-1:0]       code;
  logic [CELL_INDEX_W-1:0] rd_index;

  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic               scroll_r, scroll_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic [ATTR_W-1:0]  attr_r;
  logic               rd_ok_r;
  logic [CURSOR_W-1:0] res_cursor_r;
  logic [VALUE_W-1:0]  res_value_r;
  logic                res_scrolled_r;

  logic               last_col, last_row, is_nl, line_step;
  logic [ADDR_W-1:0]  pos_now, pos_nxt;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [VALUE_W-1:0] ram_wdata, ram_rdata;

  assign op       = tcw_op_t'(in_tdata[OPCODE_W-1:0]);
  assign code     = in_tdata[OPCODE_W +: CHAR_W];
  assign rd_index = in_tdata[OPCODE_W+CHAR_W +: CELL_INDEX_W];

  assign last_col  = (col_r == COL_W'(COLUMNS - 1));
  assign last_row  = (row_r == ROW_W'(ROWS - 1));
  assign is_nl     = (code == NEWLINE_CODE);
  assign line_step = is_nl || last_col;

  assign pos_now = ADDR_W'(row_r * COLUMNS) + ADDR_W'(col_r);
  assign pos_nxt = ADDR_W'(row_nxt * COLUMNS) + ADDR_W'(col_nxt);

  always_comb begin
    stat.copy_end = (idx_r == ADDR_W'(CELL_COUNT - COLUMNS));
    stat.fill_end = (idx_r == ADDR_W'(CELL_COUNT - 1));
    unique case (op)
      OP_PUT:   stat.path = (line_step && last_row) ? PATH_SCROLL : PATH_DONE;
      OP_CLEAR: stat.path = PATH_CLEAR;
      OP_READ:  stat.path = PATH_READ;
      default:  stat.path = PATH_DONE;
    endcase
  end

  // Cursor moves once, in the cycle the item is taken
  always_comb begin
    row_nxt    = row_r;
    col_nxt    = col_r;
    scroll_nxt = scroll_r;
    if (cmd.accept) begin
      scroll_nxt = 1'b0;
      unique case (op)
        OP_PUT: begin
          if (line_step) begin
            col_nxt = '0;
            if (last_row) begin
              scroll_nxt = 1'b1;
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
        OP_CLEAR: begin
          row_nxt = '0;
          col_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cmd.idx_zero) begin
      idx_nxt = '0;
    end else if (cmd.idx_last_row) begin
      idx_nxt = ADDR_W'(CELL_COUNT - COLUMNS);
    end else if (cmd.sweep != SWP_NONE) begin
      idx_nxt = idx_r + 1'b1;
    end else begin
      idx_nxt = idx_r;
    end
  end

  // Copy runs one cell behind its read: write idx-1 with the cell fetched last cycle
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = {RESET_ATTR, BLANK_CODE};
    ram_raddr = ADDR_W'(rd_index);
    unique case (cmd.sweep)
      SWP_INIT: ram_we = 1'b1;
      SWP_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = {attr_r, BLANK_CODE};
      end
      SWP_COPY: begin
        ram_we    = (idx_r != '0);
        ram_waddr = idx_r - 1'b1;
        ram_wdata = ram_rdata;
        if (!stat.copy_end) begin
          ram_raddr = ADDR_W'(idx_r + COLUMNS);
        end
      end
      default: begin
        if (cmd.accept && op == OP_PUT && !is_nl) begin
          ram_we    = 1'b1;
          ram_waddr = pos_now;
          ram_wdata = {attr_r, code};
        end
      end
    endcase
  end

  tcw_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CELL_COUNT)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      col_r    <= '0;
      scroll_r <= 1'b0;
      idx_r    <= '0;
      attr_r   <= RESET_ATTR;
    end else begin
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      scroll_r <= scroll_nxt;
      idx_r    <= idx_nxt;
      if (cfg_valid) begin
        attr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_ok_r <= (32'(rd_index) < 32'(CELL_COUNT));
    end
    if (cmd.load_result) begin
      res_cursor_r   <= CURSOR_W'(pos_nxt);
      res_value_r    <= (cmd.result_from_ram && rd_ok_r) ? ram_rdata : '0;
      res_scrolled_r <= scroll_nxt;
    end
  end

  assign out_tdata = {{OUT_PAD{1'b0}}, res_scrolled_r, res_value_r, res_cursor_r};

endmodule

`default_nettype wire

[rtl/core/text_console_writer.sv]
// Text console writer: a ROWS x COLUMNS screen of 16-bit cells (attribute in the
// high byte, character in the low byte) with a cursor, driven by a word stream.
// Input words carry opcode (put, clear, read, no-op), a character and a cell index; each
// accepted word yields exactly one output word holding the linear cursor index,
// the cell read (zero for anything but an in-range read) and a scrolled flag.
// The attribute register is written over the cfg channel, always ready, and
// must only change while the block is idle.
// Path of each word from acceptance to the output register:
//   put without scroll, no-op : loaded on acceptance; a word each cycle unless output is held
//   read                      : through the S_READ state (registered memory read)
//   clear                     : through the fill sweep
//   put that scrolls          : through the copy sweep, then the fill sweep
// Clear and scroll walk the screen memory one cell per cycle through its single
// write port; scroll copies each row up one behind its read, then blanks the
// bottom row. After reset the block first blanks every cell with attribute 7,
// holding in_tready low until that sweep ends.
// A stalled receiver holds the output word; the next input word is taken
// as soon as the held word leaves.
`default_nettype none

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input words
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_W-1:0]   in_tdata,   // opcode[1:0], char_code[9:2], cell_index[20:10]
  // Result words
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [OUT_W-1:0]  out_tdata,  // cursor_index[10:0], cell_value[26:11], scrolled[27]
  // Attribute register write
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [ATTR_W-1:0] cfg_data
);

  tcw_cmd_t  cmd;
  tcw_stat_t stat;

  // Attribute writes are always taken
  assign cfg_ready = 1'b1;

  // Sequence accept, sweeps and result loading
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold cursor, attribute, screen memory and the result word
  tcw_dp #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_tdata (in_tdata),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .out_tdata(out_tdata)
  );

endmodule

`default_nettype wire

[tb/tb_text_console_writer.sv]
`default_nettype none

module tb_text_console_writer
  import tcw_pkg::*;
();

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = COLUMNS * ROWS;
  // Cap on clears and scrolls in the random part: each one walks the whole screen
  localparam int HEAVY_CAP  = 220;
  localparam int SEG_WORDS  = 100;
  localparam int SEG_COUNT  = 15;
  localparam int LONG_HOLD  = 300;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor;
    logic [VALUE_W-1:0]  value;
    logic                scrolled;
  } console_result_t;

  typedef struct packed {
    logic            typed;
    console_result_t res;
  } typed_result_t;

  typedef struct {
    bit                      cfg;
    tcw_op_t                 op;
    logic [CHAR_W-1:0]       ch;
    logic [CELL_INDEX_W-1:0] idx;
    int                      reps;
    bit                      typed;
    console_result_t         res;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ATTR_W-1:0] cfg_data = '0;

  // Screen copy kept alongside the block
  logic [VALUE_W-1:0] screen_copy [CELLS];
  int                 cur_row;
  int                 cur_col;
  logic [ATTR_W-1:0]  cur_attr;

  console_result_t pending_results [$];
  typed_result_t   typed_results [$];
  plan_row_t       plan [$];

  int  mismatch_count = 0;
  int  heavy_ops = 0;
  bit  calm = 1'b0;
  bit  long_hold_req = 1'b0;

  text_console_writer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // opcode[1:0], char_code[9:2], cell_index[20:10]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // cursor_index[10:0], cell_value[26:11], scrolled[27]
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Console predictor
  // ---------------------------------------------------------------------------

  // Fill the whole screen copy with blanks in the current attribute
  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen_copy[i] = {cur_attr, BLANK_CODE};
  endfunction

  // Move to the start of the next line; scroll when falling off the bottom
  function automatic logic line_feed();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen_copy[i] = screen_copy[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_copy[i] = {cur_attr, BLANK_CODE};
      cur_row = ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one accepted word to the screen copy and work out its result word
  function automatic console_result_t console_step(logic [IN_W-1:0] w);
    tcw_op_t                 op;
    logic [CHAR_W-1:0]       ch;
    logic [CELL_INDEX_W-1:0] idx;
    console_result_t         r;
    int                      lin;
    op  = tcw_op_t'(w[1:0]);
    ch  = w[9:2];
    idx = w[20:10];
    r   = '0;
    case (op)
      OP_PUT: begin
        if (ch == NEWLINE_CODE) begin
          r.scrolled = line_feed();
        end else begin
          screen_copy[cur_row * COLUMNS + cur_col] = {cur_attr, ch};
          cur_col++;
          if (cur_col >= COLUMNS) r.scrolled = line_feed();
        end
      end
      OP_CLEAR: begin
        blank_screen();
        cur_row = 0;
        cur_col = 0;
      end
      OP_READ: begin
        if (idx < CELLS) r.value = screen_copy[idx];
      end
      default: ;
    endcase
    lin = cur_row * COLUMNS + cur_col;
    r.cursor = lin[CURSOR_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors: all sample at the rising edge, before the block's registers move
  // ---------------------------------------------------------------------------

  // Predict each accepted word; a typed-in expectation, where present, wins
  always @(posedge clk) begin
    console_result_t pred;
    typed_result_t   t;
    if (rst_n && in_tvalid && in_tready) begin
      pred = console_step(in_tdata);
      if (tcw_op_t'(in_tdata[1:0]) == OP_CLEAR || pred.scrolled) heavy_ops++;
      t = '0;
      if (typed_results.size() != 0) t = typed_results.pop_front();
      pending_results.push_back(t.typed ? t.res : pred);
    end
  end

  // Track the attribute register as the block sees it
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) cur_attr = cfg_data;
  end

  // Check every result word against the oldest expectation
  always @(posedge clk) begin
    console_result_t got;
    console_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.cursor   = out_tdata[10:0];
      got.value    = out_tdata[26:11];
      got.scrolled = out_tdata[27];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: cursor %0d value %h scrolled %0d",
                   got.cursor, got.value, got.scrolled);
      end else begin
        want = pending_results.pop_front();
        if (got.cursor !== want.cursor || got.value !== want.value ||
            got.scrolled !== want.scrolled) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: cursor %0d/%0d value %h/%h scrolled %0d/%0d (exp/got)",
                     want.cursor, got.cursor, want.value, got.value,
                     want.scrolled, got.scrolled);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure in bursts, plus one long hold on request
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    int gap_left;
    hold_left = 0;
    gap_left  = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        // Hold off long enough for the output word to back up into the input
        hold_left--;
        out_tready <= 1'b0;
      end else if (!calm && gap_left > 0) begin
        gap_left--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 4) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one word and hold it until taken; leaves in_tvalid high afterwards
  task automatic send_word(logic [IN_W-1:0] w, typed_result_t t);
    int gap;
    typed_results.push_back(t);
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
  endtask

  // Wait for the block to drain, then write the attribute register
  task automatic write_attr(logic [ATTR_W-1:0] v);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_row(bit cfg, tcw_op_t op, logic [CHAR_W-1:0] ch,
                                  logic [CELL_INDEX_W-1:0] idx, int reps, bit typed,
                                  logic [CURSOR_W-1:0] cur, logic [VALUE_W-1:0] val,
                                  logic scr);
    plan_row_t p;
    p.cfg = cfg;  p.op = op;  p.ch = ch;  p.idx = idx;  p.reps = reps;
    p.typed = typed;
    p.res.cursor = cur;  p.res.value = val;  p.res.scrolled = scr;
    plan.push_back(p);
  endfunction

  // Random word shaped by segment kind: 0 text, 1 newline-heavy, 2 read-heavy
  function automatic logic [IN_W-1:0] random_word(int kind);
    int                      r;
    tcw_op_t                 op;
    logic [CHAR_W-1:0]       ch;
    logic [CELL_INDEX_W-1:0] idx;
    int                      nl_pct;
    int                      a;
    r  = $urandom_range(0, 99);
    ch = CHAR_W'($urandom_range(0, 255));
    case (kind)
      0:       begin op = (r < 60) ? OP_PUT : (r < 86) ? OP_READ : (r < 89) ? OP_CLEAR : OP_NOP;
                     nl_pct = 8; end
      1:       begin op = (r < 80) ? OP_PUT : (r < 95) ? OP_READ : (r < 97) ? OP_NOP : OP_CLEAR;
                     nl_pct = 50; end
      default: begin op = (r < 30) ? OP_PUT : (r < 95) ? OP_READ : (r < 97) ? OP_CLEAR : OP_NOP;
                     nl_pct = 10; end
    endcase
    if (op == OP_PUT && $urandom_range(0, 99) < nl_pct) ch = NEWLINE_CODE;
    // Reads mostly near the cursor, some anywhere, a few past the end
    r = $urandom_range(0, 9);
    if (r < 5) begin
      a = cur_row * COLUMNS + $urandom_range(0, 2 * COLUMNS - 1) - COLUMNS / 2;
      if (a < 0) a = 0;
      idx = a[CELL_INDEX_W-1:0];
    end else if (r < 9) begin
      idx = CELL_INDEX_W'($urandom_range(0, CELLS - 1));
    end else begin
      idx = CELL_INDEX_W'($urandom_range(0, 2047));
    end
    // Past the budget, swap anything that would sweep the screen for a read
    if (heavy_ops >= HEAVY_CAP) begin
      if (op == OP_CLEAR) op = OP_READ;
      if (op == OP_PUT && cur_row == ROWS - 1 &&
          (ch == NEWLINE_CODE || cur_col == COLUMNS - 1)) op = OP_READ;
    end
    return {3'b000, idx, ch, op};
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    typed_result_t t;
    int            wait_cycles;
    cur_attr = RESET_ATTR;
    blank_screen();
    cur_row = 0;
    cur_col = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: reset state, field extremes, wrap, scroll, attribute extremes
    add_row(0, OP_READ,  8'h00, 11'd0,    1, 1, 11'd0,    16'h0720, 1'b0);
    add_row(0, OP_READ,  8'hFF, 11'd1999, 1, 1, 11'd0,    16'h0720, 1'b0);
    add_row(0, OP_READ,  8'h00, 11'd2000, 1, 1, 11'd0,    16'h0000, 1'b0);
    add_row(0, OP_READ,  8'h00, 11'd2047, 1, 1, 11'd0,    16'h0000, 1'b0);
    add_row(0, OP_NOP,   8'hFF, 11'd2047, 1, 1, 11'd0,    16'h0000, 1'b0);
    add_row(0, OP_PUT,   8'h41, 11'd2047, 1, 1, 11'd1,    16'h0000, 1'b0);
    add_row(0, OP_PUT,   8'h00, 11'd0,    1, 0, '0, '0, 1'b0);
    add_row(0, OP_PUT,   8'hFF, 11'd0,    1, 0, '0, '0, 1'b0);
    add_row(0, OP_PUT,   NEWLINE_CODE, 11'd0, 1, 1, 11'd80, 16'h0000, 1'b0);
    add_row(0, OP_READ,  8'h00, 11'd0,    1, 1, 11'd80,   16'h0741, 1'b0);
    add_row(0, OP_CLEAR, 8'hFF, 11'd2047, 1, 1, 11'd0,    16'h0000, 1'b0);
    add_row(0, OP_PUT,   8'h58, 11'd0,   79, 0, '0, '0, 1'b0);
    // Last column written: cursor wraps to the next row without a scroll
    add_row(0, OP_PUT,   8'h59, 11'd0,    1, 1, 11'd80,   16'h0000, 1'b0);
    add_row(0, OP_PUT,   NEWLINE_CODE, 11'd0, 23, 0, '0, '0, 1'b0);
    // Newline on the bottom row scrolls
    add_row(0, OP_PUT,   NEWLINE_CODE, 11'd0, 1, 1, 11'd1920, 16'h0000, 1'b1);
    add_row(0, OP_READ,  8'h00, 11'd0,    1, 0, '0, '0, 1'b0);
    add_row(0, OP_PUT,   8'h41, 11'd0,   79, 0, '0, '0, 1'b0);
    // Wrap off the bottom row scrolls as well
    add_row(0, OP_PUT,   8'h42, 11'd0,    1, 1, 11'd1920, 16'h0000, 1'b1);
    add_row(0, OP_READ,  8'h00, 11'd1919, 1, 1, 11'd1920, 16'h0742, 1'b0);
    add_row(0, OP_READ,  8'h00, 11'd1999, 1, 1, 11'd1920, 16'h0720, 1'b0);
    add_row(1, OP_NOP,   8'hFF, 11'd0,    1, 0, '0, '0, 1'b0);
    add_row(0, OP_CLEAR, 8'h00, 11'd0,    1, 1, 11'd0,    16'h0000, 1'b0);
    add_row(0, OP_READ,  8'h00, 11'd0,    1, 1, 11'd0,    16'hFF20, 1'b0);
    add_row(0, OP_PUT,   8'h00, 11'd0,    1, 1, 11'd1,    16'h0000, 1'b0);
    add_row(0, OP_READ,  8'h00, 11'd0,    1, 1, 11'd1,    16'hFF00, 1'b0);
    add_row(1, OP_NOP,   8'h00, 11'd0,    1, 0, '0, '0, 1'b0);
    add_row(0, OP_CLEAR, 8'h00, 11'd0,    1, 1, 11'd0,    16'h0000, 1'b0);
    add_row(0, OP_READ,  8'h00, 11'd1999, 1, 1, 11'd0,    16'h0020, 1'b0);

    foreach (plan[i]) begin
      if (plan[i].cfg) begin
        write_attr(plan[i].ch);
      end else begin
        for (int k = 0; k < plan[i].reps; k++) begin
          t.typed = plan[i].typed;
          t.res   = plan[i].res;
          send_word({3'b000, plan[i].idx, plan[i].ch, plan[i].op}, t);
        end
      end
    end

    // Random part: segments of words, attribute changed between them
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      case (seg)
        0:       write_attr(8'h00);
        1:       write_attr(8'hFF);
        default: write_attr(ATTR_W'($urandom_range(0, 255)));
      endcase
      // Drop all idling for the closing segments
      if (seg >= SEG_COUNT - 2) calm = 1'b1;
      if (seg == 2) long_hold_req = 1'b1;
      for (int n = 0; n < SEG_WORDS; n++) begin
        t = '0;
        send_word(random_word(seg % 3), t);
      end
    end

    // Drain: wait for every expected word, then a little longer
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatch_count++;
      $display("%0d expected words never arrived", pending_results.size());
    end

    if (mismatch_count == 0) begin
      $display("tb_text_console_writer OK");
    end else begin
      $display("tb_text_console_writer NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #16000000;
    $display("tb_text_console_writer NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl/core
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_dp.sv
rtl/core/text_console_writer.sv
tb/tb_text_console_writer.sv
